/* src/asmf_pkg.sv */
// shared constants, types and helpers of the adc scan median filter
package asmf_pkg;

	localparam int CHANNEL_SLOTS     = 5;
	localparam int SAMPLE_ROUNDS_DEF = 8;
	localparam int SAMPLE_BITS_DEF   = 12;
	localparam int SAMPLE_PORT_BITS  = 12;
	localparam int CHANNEL_BITS      = 4;
	localparam int SLOT_BITS         = 3;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [CHANNEL_BITS-1:0] CH_SLOT0 = 4'd10;
	localparam logic [CHANNEL_BITS-1:0] CH_SLOT1 = 4'd11;
	localparam logic [CHANNEL_BITS-1:0] CH_SLOT2 = 4'd12;
	localparam logic [CHANNEL_BITS-1:0] CH_SLOT3 = 4'd13;
	localparam logic [CHANNEL_BITS-1:0] CH_SLOT4 = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAND,
		ST_FIRST,
		ST_CMP,
		ST_CHECK,
		ST_DONE
	} asmf_state_t;

	typedef struct packed {
		logic tick_go;
		logic query_go;
		logic cand_rd;
		logic cand_cap;
		logic cmp_rd;
		logic cmp_acc;
		logic cand_next;
		logic med_load;
	} asmf_cmd_t;

	typedef struct packed {
		logic out_free;
		logic cmp_end;
		logic hit;
		logic slot_ok;
	} asmf_status_t;

	function automatic logic [CHANNEL_BITS-1:0] slot_channel(input logic [SLOT_BITS-1:0] slot);
		logic [CHANNEL_BITS-1:0] ch;
		case (slot)
			3'd0: ch = CH_SLOT0;
			3'd1: ch = CH_SLOT1;
			3'd2: ch = CH_SLOT2;
			3'd3: ch = CH_SLOT3;
			3'd4: ch = CH_SLOT4;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

/* src/asmf_ram.sv */
// generic single-write single-read ram with registered read data
module asmf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 40
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/asmf_ctrl.sv */
// controller state machine: transfer acceptance and median rank search sequencing
module asmf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   action,
	output logic                   in_stall,
	input  asmf_pkg::asmf_status_t st,
	output asmf_pkg::asmf_cmd_t    cmd
);

	asmf_pkg::asmf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			asmf_pkg::ST_IDLE: begin
				if (in_valid && st.out_free && action == asmf_pkg::ACT_QUERY) begin
					state_d = asmf_pkg::ST_CAND;
				end
			end
			asmf_pkg::ST_CAND: begin
				state_d = st.slot_ok ? asmf_pkg::ST_FIRST : asmf_pkg::ST_DONE;
			end
			asmf_pkg::ST_FIRST: begin
				state_d = asmf_pkg::ST_CMP;
			end
			asmf_pkg::ST_CMP: begin
				if (st.cmp_end) begin
					state_d = asmf_pkg::ST_CHECK;
				end
			end
			asmf_pkg::ST_CHECK: begin
				state_d = st.hit ? asmf_pkg::ST_DONE : asmf_pkg::ST_CAND;
			end
			asmf_pkg::ST_DONE: begin
				if (st.out_free) begin
					state_d = asmf_pkg::ST_IDLE;
				end
			end
			default: state_d = asmf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			asmf_pkg::ST_IDLE: begin
				in_stall = !st.out_free;
				if (in_valid && st.out_free) begin
					cmd.tick_go  = (action == asmf_pkg::ACT_TICK);
					cmd.query_go = (action == asmf_pkg::ACT_QUERY);
				end
			end
			asmf_pkg::ST_CAND: begin
				cmd.cand_rd = st.slot_ok;
			end
			asmf_pkg::ST_FIRST: begin
				cmd.cand_cap = 1'b1;
				cmd.cmp_rd   = 1'b1;
			end
			asmf_pkg::ST_CMP: begin
				cmd.cmp_acc = 1'b1;
				cmd.cmp_rd  = !st.cmp_end;
			end
			asmf_pkg::ST_CHECK: begin
				cmd.cand_next = !st.hit;
			end
			asmf_pkg::ST_DONE: begin
				cmd.med_load = st.out_free;
			end
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

/* src/asmf_dp.sv */
// datapath: scan counters, sample store with valid flags, rank counters, output register
module asmf_dp #(
	parameter int SAMPLE_ROUNDS = asmf_pkg::SAMPLE_ROUNDS_DEF,
	parameter int SAMPLE_BITS   = asmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  asmf_pkg::asmf_cmd_t                     cmd,
	output asmf_pkg::asmf_status_t                  st,
	input  logic [asmf_pkg::SAMPLE_PORT_BITS-1:0]   sample,
	input  logic [asmf_pkg::SLOT_BITS-1:0]          query_channel,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    start_valid,
	output logic [asmf_pkg::CHANNEL_BITS-1:0]       start_channel,
	output logic                                    stored_valid,
	output logic                                    median_valid,
	output logic [asmf_pkg::SAMPLE_PORT_BITS-1:0]   median_value
);

	localparam int Depth = SAMPLE_ROUNDS * asmf_pkg::CHANNEL_SLOTS;
	localparam int AddrW = $clog2(Depth);
	localparam int RowW  = SAMPLE_ROUNDS > 1 ? $clog2(SAMPLE_ROUNDS) : 1;
	localparam int CntW  = $clog2(SAMPLE_ROUNDS + 1);
	localparam int MedRank = (SAMPLE_ROUNDS - 1) / 2;

	logic                               setup_q;
	logic [asmf_pkg::SLOT_BITS-1:0]     slot_q;
	logic [RowW-1:0]                    round_q;
	logic [Depth-1:0]                   vld_q;
	logic [RowW-1:0]                    cand_row_q;
	logic [CntW-1:0]                    cmp_row_q;
	logic [asmf_pkg::SLOT_BITS-1:0]     qslot_q;
	logic [SAMPLE_BITS-1:0]             cand_val_q;
	logic [CntW-1:0]                    less_q;
	logic [CntW-1:0]                    leq_q;
	logic                               rvld_s1;
	logic                               out_valid_q;
	logic                               start_valid_q;
	logic [asmf_pkg::CHANNEL_BITS-1:0]  start_channel_q;
	logic                               stored_valid_q;
	logic                               median_valid_q;
	logic [asmf_pkg::SAMPLE_PORT_BITS-1:0] median_value_q;

	logic                               wr_en;
	logic [AddrW-1:0]                   waddr;
	logic [SAMPLE_BITS-1:0]             wdata;
	logic                               rd_en;
	logic [RowW-1:0]                    rd_row;
	logic [AddrW-1:0]                   raddr;
	logic [SAMPLE_BITS-1:0]             rdata;
	logic [SAMPLE_BITS-1:0]             rval;
	logic                               last_slot;

	assign wr_en     = cmd.tick_go && !setup_q;
	assign waddr     = AddrW'(32'(round_q) * asmf_pkg::CHANNEL_SLOTS + 32'(slot_q));
	assign wdata     = SAMPLE_BITS'(sample);
	assign rd_en     = cmd.cand_rd || cmd.cmp_rd;
	assign rd_row    = cmd.cand_rd ? cand_row_q : cmp_row_q[RowW-1:0];
	assign raddr     = AddrW'(32'(rd_row) * asmf_pkg::CHANNEL_SLOTS + 32'(qslot_q));
	assign rval      = rvld_s1 ? rdata : '0;
	assign last_slot = (slot_q == asmf_pkg::SLOT_BITS'(asmf_pkg::CHANNEL_SLOTS - 1));

	asmf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(Depth)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign st.out_free = !out_valid_q || !out_stall;
	assign st.cmp_end  = (cmp_row_q == CntW'(SAMPLE_ROUNDS));
	assign st.hit      = (less_q <= CntW'(MedRank)) && (leq_q > CntW'(MedRank));
	assign st.slot_ok  = (qslot_q < asmf_pkg::SLOT_BITS'(asmf_pkg::CHANNEL_SLOTS));

	// scan sequencer state and per-entry valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= 1'b1;
			slot_q  <= '0;
			round_q <= '0;
			vld_q   <= '0;
		end else if (cmd.tick_go) begin
			setup_q <= !setup_q;
			if (!setup_q) begin
				vld_q[waddr] <= 1'b1;
				if (last_slot) begin
					slot_q <= '0;
					if (round_q == RowW'(SAMPLE_ROUNDS - 1)) begin
						round_q <= '0;
					end else begin
						round_q <= round_q + 1'b1;
					end
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	// rank search
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rvld_s1 <= vld_q[raddr];
		end
		if (cmd.query_go) begin
			qslot_q    <= query_channel;
			cand_row_q <= '0;
		end else if (cmd.cand_next) begin
			cand_row_q <= cand_row_q + 1'b1;
		end
		if (cmd.cand_rd) begin
			cmp_row_q <= '0;
			less_q    <= '0;
			leq_q     <= '0;
		end else begin
			if (cmd.cmp_rd) begin
				cmp_row_q <= cmp_row_q + 1'b1;
			end
			if (cmd.cmp_acc) begin
				less_q <= less_q + CntW'(rval < cand_val_q);
				leq_q  <= leq_q + CntW'(rval <= cand_val_q);
			end
		end
		if (cmd.cand_cap) begin
			cand_val_q <= rval;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tick_go || cmd.med_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_go) begin
			start_valid_q   <= setup_q;
			start_channel_q <= setup_q ? asmf_pkg::slot_channel(slot_q) : '0;
			stored_valid_q  <= !setup_q;
			median_valid_q  <= 1'b0;
			median_value_q  <= '0;
		end else if (cmd.med_load) begin
			start_valid_q   <= 1'b0;
			start_channel_q <= '0;
			stored_valid_q  <= 1'b0;
			median_valid_q  <= 1'b1;
			median_value_q  <= st.slot_ok ? asmf_pkg::SAMPLE_PORT_BITS'(cand_val_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign start_valid   = start_valid_q;
	assign start_channel = start_channel_q;
	assign stored_valid  = stored_valid_q;
	assign median_valid  = median_valid_q;
	assign median_value  = median_value_q;

endmodule

/* src/adc_scan_median_filter_top.sv */
// top level of the adc scan sequencer with per-channel median filter
// scan tick: result registered in the cycle after its transfer; the next tick is
//   taken right after unless out_stall holds the output
// median query: candidate rows tried in turn, each against all rows by serial ram reads
// reset: set-up phase, slot 0, round 0; store reads as zero through per-entry valid flags
module adc_scan_median_filter_top #(
	parameter int SAMPLE_ROUNDS = asmf_pkg::SAMPLE_ROUNDS_DEF,
	parameter int SAMPLE_BITS   = asmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	input  logic [asmf_pkg::SAMPLE_PORT_BITS-1:0] sample,
	input  logic [asmf_pkg::SLOT_BITS-1:0]        query_channel,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  start_valid,
	output logic [asmf_pkg::CHANNEL_BITS-1:0]     start_channel,
	output logic                                  stored_valid,
	output logic                                  median_valid,
	output logic [asmf_pkg::SAMPLE_PORT_BITS-1:0] median_value
);

	asmf_pkg::asmf_cmd_t    cmd;
	asmf_pkg::asmf_status_t st;

	asmf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (action),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	asmf_dp #(
		.SAMPLE_ROUNDS(SAMPLE_ROUNDS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.sample       (sample),
		.query_channel(query_channel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_valid  (start_valid),
		.start_channel(start_channel),
		.stored_valid (stored_valid),
		.median_valid (median_valid),
		.median_value (median_value)
	);

endmodule
